/* design/lob_pkg.sv */
// Shared types, codes and default sizes of the limit order book top-levels block.
package lob_pkg;

    localparam int DEF_ORDER_SLOTS  = 1024;
    localparam int DEF_BOOK_LEVELS  = 64;
    localparam int DEF_REPORT_DEPTH = 10;

    typedef enum logic [1:0] {
        FUNC_ADD    = 2'd0,
        FUNC_CANCEL = 2'd1,
        FUNC_MODIFY = 2'd2,
        FUNC_OTHER  = 2'd3
    } t_func;

    localparam logic [1:0] SIDE_BID = 2'd0;
    localparam logic [1:0] SIDE_ASK = 2'd1;

    localparam logic [1:0] ST_OK          = 2'd0;
    localparam logic [1:0] ST_TABLE_FULL  = 2'd1;
    localparam logic [1:0] ST_LEVELS_FULL = 2'd2;

    typedef struct packed {
        t_func              func;
        logic [1:0]         side;
        logic [63:0]        order_key;
        logic signed [31:0] price_ticks;
        logic [30:0]        quantity;
    } t_in_item;

    typedef struct packed {
        logic [3:0]         level;
        logic signed [31:0] bid_price;
        logic [31:0]        bid_total;
        logic               bid_present;
        logic signed [31:0] ask_price;
        logic [31:0]        ask_total;
        logic               ask_present;
        logic [1:0]         status;
        logic               last;
    } t_out_item;

    typedef struct packed {
        logic               valid;
        logic [1:0]         side;
        logic [30:0]        qty;
        logic signed [31:0] price;
        logic [63:0]        key;
    } t_slot;

    typedef struct packed {
        logic signed [31:0] price;
        logic [31:0]        total;
    } t_lvl;

    typedef enum logic [4:0] {
        S_CLR, S_IDLE, S_DISPATCH,
        S_CAN_RD, S_CAN_CK, S_CAN_FREE,
        S_ADD_INIT, S_ADD_RD, S_ADD_CK, S_ADD_STORE,
        S_LV_CHK, S_LV_RD, S_LV_CK, S_LV_UPD,
        S_REM_CHK, S_REM_RD, S_REM_WR,
        S_INS_CHK, S_INS_LOOP, S_INS_RD, S_INS_WR, S_INS_PUT,
        S_SNAP_INIT, S_SNAP_RD, S_SNAP_OUT
    } t_state;

    typedef enum logic [4:0] {
        OP_NONE, OP_CLR, OP_LATCH, OP_SCAN_INIT, OP_SCAN_RD, OP_SCAN_CK,
        OP_REM_SETUP, OP_ADD_STORE, OP_LV_RD, OP_LV_CK, OP_LV_SATADD, OP_LV_SUB,
        OP_REM_START, OP_REM_RD, OP_REM_WR, OP_CNT_DEC,
        OP_INS_START, OP_INS_RD, OP_INS_WR, OP_INS_PUT,
        OP_SNAP_INIT, OP_SNAP_RD, OP_SNAP_LOAD
    } t_op;

    typedef struct packed {
        t_op op;
    } t_cmd;

    typedef struct packed {
        t_func func;
        logic  clr_last;
        logic  hit;
        logic  scan_last;
        logic  tbl_full;
        logic  old_side_ok;
        logic  in_side_ok;
        logic  rem;
        logic  lv_done;
        logic  lv_hit;
        logic  rem_drop;
        logic  rem_more;
        logic  lv_full;
        logic  ins_more;
        logic  out_free;
        logic  snap_last;
    } t_dp_stat;

endpackage

/* design/lob_ctrl.sv */
// Sequencer of the order book: walks each event through lookup, level update and snapshot.
module lob_ctrl (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_in_valid,
    output logic              o_in_stall,
    input  lob_pkg::t_dp_stat i_stat,
    output lob_pkg::t_cmd     o_cmd
);
    import lob_pkg::*;

    t_state r_state;
    t_state n_state;
    t_state after_level;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_CLR;
        end else begin
            r_state <= n_state;
        end
    end

    always_comb begin
        n_state    = r_state;
        o_cmd.op   = OP_NONE;
        o_in_stall = 1'b1;
        after_level = (i_stat.rem && i_stat.func == FUNC_MODIFY) ? S_ADD_INIT : S_SNAP_INIT;
        case (r_state)
            S_CLR: begin
                o_cmd.op = OP_CLR;
                if (i_stat.clr_last) n_state = S_IDLE;
            end
            S_IDLE: begin
                o_in_stall = 1'b0;
                if (i_in_valid) begin
                    o_cmd.op = OP_LATCH;
                    n_state  = S_DISPATCH;
                end
            end
            S_DISPATCH: begin
                case (i_stat.func)
                    FUNC_ADD:    n_state = S_ADD_RD;
                    FUNC_CANCEL: n_state = S_CAN_RD;
                    FUNC_MODIFY: n_state = S_CAN_RD;
                    default:     n_state = S_SNAP_INIT;
                endcase
            end
            S_CAN_RD: begin
                o_cmd.op = OP_SCAN_RD;
                n_state  = S_CAN_CK;
            end
            S_CAN_CK: begin
                o_cmd.op = OP_SCAN_CK;
                if (i_stat.hit) begin
                    n_state = S_CAN_FREE;
                end else if (i_stat.scan_last) begin
                    n_state = (i_stat.func == FUNC_MODIFY) ? S_ADD_INIT : S_SNAP_INIT;
                end else begin
                    n_state = S_CAN_RD;
                end
            end
            S_CAN_FREE: begin
                o_cmd.op = OP_REM_SETUP;
                if (i_stat.old_side_ok) begin
                    n_state = S_LV_CHK;
                end else begin
                    n_state = (i_stat.func == FUNC_MODIFY) ? S_ADD_INIT : S_SNAP_INIT;
                end
            end
            S_ADD_INIT: begin
                o_cmd.op = OP_SCAN_INIT;
                n_state  = S_ADD_RD;
            end
            S_ADD_RD: begin
                o_cmd.op = OP_SCAN_RD;
                n_state  = S_ADD_CK;
            end
            S_ADD_CK: begin
                o_cmd.op = OP_SCAN_CK;
                n_state  = (i_stat.hit || i_stat.scan_last) ? S_ADD_STORE : S_ADD_RD;
            end
            S_ADD_STORE: begin
                o_cmd.op = OP_ADD_STORE;
                n_state  = (!i_stat.tbl_full && i_stat.in_side_ok) ? S_LV_CHK : S_SNAP_INIT;
            end
            S_LV_CHK: begin
                if (!i_stat.lv_done) begin
                    n_state = S_LV_RD;
                end else begin
                    n_state = i_stat.rem ? after_level : S_INS_CHK;
                end
            end
            S_LV_RD: begin
                o_cmd.op = OP_LV_RD;
                n_state  = S_LV_CK;
            end
            S_LV_CK: begin
                o_cmd.op = OP_LV_CK;
                n_state  = i_stat.lv_hit ? S_LV_UPD : S_LV_CHK;
            end
            S_LV_UPD: begin
                if (!i_stat.rem) begin
                    o_cmd.op = OP_LV_SATADD;
                    n_state  = S_SNAP_INIT;
                end else if (i_stat.rem_drop) begin
                    o_cmd.op = OP_REM_START;
                    n_state  = S_REM_CHK;
                end else begin
                    o_cmd.op = OP_LV_SUB;
                    n_state  = after_level;
                end
            end
            S_REM_CHK: begin
                if (i_stat.rem_more) begin
                    n_state = S_REM_RD;
                end else begin
                    o_cmd.op = OP_CNT_DEC;
                    n_state  = after_level;
                end
            end
            S_REM_RD: begin
                o_cmd.op = OP_REM_RD;
                n_state  = S_REM_WR;
            end
            S_REM_WR: begin
                o_cmd.op = OP_REM_WR;
                n_state  = S_REM_CHK;
            end
            S_INS_CHK: begin
                o_cmd.op = OP_INS_START;
                n_state  = i_stat.lv_full ? S_SNAP_INIT : S_INS_LOOP;
            end
            S_INS_LOOP: begin
                n_state = i_stat.ins_more ? S_INS_RD : S_INS_PUT;
            end
            S_INS_RD: begin
                o_cmd.op = OP_INS_RD;
                n_state  = S_INS_WR;
            end
            S_INS_WR: begin
                o_cmd.op = OP_INS_WR;
                n_state  = S_INS_LOOP;
            end
            S_INS_PUT: begin
                o_cmd.op = OP_INS_PUT;
                n_state  = S_SNAP_INIT;
            end
            S_SNAP_INIT: begin
                o_cmd.op = OP_SNAP_INIT;
                n_state  = S_SNAP_RD;
            end
            S_SNAP_RD: begin
                o_cmd.op = OP_SNAP_RD;
                n_state  = S_SNAP_OUT;
            end
            S_SNAP_OUT: begin
                if (i_stat.out_free) begin
                    o_cmd.op = OP_SNAP_LOAD;
                    n_state  = i_stat.snap_last ? S_IDLE : S_SNAP_RD;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

endmodule

/* design/lob_dpath.sv */
// Datapath of the order book: order table, both level stores, counters and the output register.
module lob_dpath #(
    parameter int ORDER_SLOTS  = lob_pkg::DEF_ORDER_SLOTS,
    parameter int BOOK_LEVELS  = lob_pkg::DEF_BOOK_LEVELS,
    parameter int REPORT_DEPTH = lob_pkg::DEF_REPORT_DEPTH
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  lob_pkg::t_in_item  i_in_item,
    input  lob_pkg::t_cmd      i_cmd,
    output lob_pkg::t_dp_stat  o_stat,
    output logic               o_out_valid,
    input  logic               i_out_stall,
    output lob_pkg::t_out_item o_out_item
);
    import lob_pkg::*;

    localparam int SW  = $clog2(ORDER_SLOTS);
    localparam int LW  = $clog2(BOOK_LEVELS);
    localparam int CW  = $clog2(BOOK_LEVELS + 1);
    localparam int RCW = $clog2(REPORT_DEPTH + 1);
    localparam int XW  = (RCW > CW) ? RCW : CW;

    t_slot r_slot_mem [ORDER_SLOTS];
    t_lvl  r_bid_mem  [BOOK_LEVELS];
    t_lvl  r_ask_mem  [BOOK_LEVELS];

    t_slot r_slot_rd;
    t_lvl  r_bid_rd;
    t_lvl  r_ask_rd;

    t_in_item           r_in;
    logic [SW-1:0]      r_ci;
    logic [SW-1:0]      r_si;
    logic               r_found;
    logic [SW-1:0]      r_fslot;
    logic               r_free_found;
    logic [SW-1:0]      r_free;
    logic [1:0]         r_old_side;
    logic signed [31:0] r_old_price;
    logic [30:0]        r_old_qty;
    logic               r_lside;
    logic signed [31:0] r_lprice;
    logic [30:0]        r_lqty;
    logic               r_rem;
    logic [CW-1:0]      r_li;
    logic [LW-1:0]      r_hit_idx;
    logic [31:0]        r_hit_tot;
    logic [CW-1:0]      r_pos;
    logic               r_pos_found;
    logic [CW-1:0]      r_j;
    logic [1:0]         r_status;
    logic [RCW-1:0]     r_r;
    logic [CW-1:0]      r_bid_cnt;
    logic [CW-1:0]      r_ask_cnt;
    logic               r_out_valid;
    t_out_item          r_out;

    logic          slot_we;
    logic [SW-1:0] slot_waddr;
    t_slot         slot_wdata;
    logic          slot_re;
    logic          lv_we;
    logic [LW-1:0] lv_waddr;
    t_lvl          lv_wdata;
    logic          lv_re;
    logic [LW-1:0] lv_raddr;

    t_lvl          lv_rd;
    logic [CW-1:0] lv_cnt;
    logic [CW-1:0] in_side_cnt;
    logic          hit_now;
    logic          lv_hit_now;
    logic          ahead;
    logic [32:0]   sat_sum;
    logic          bid_pres;
    logic          ask_pres;
    logic          out_free;
    logic          tbl_full;

    assign lv_rd       = r_lside ? r_ask_rd : r_bid_rd;
    assign lv_cnt      = r_lside ? r_ask_cnt : r_bid_cnt;
    assign in_side_cnt = r_in.side[0] ? r_ask_cnt : r_bid_cnt;
    assign hit_now     = r_slot_rd.valid && (r_slot_rd.key == r_in.order_key);
    assign lv_hit_now  = lv_rd.price == r_lprice;
    // Bids rank high price first, asks low price first.
    assign ahead       = r_lside ? (r_lprice < lv_rd.price) : (r_lprice > lv_rd.price);
    assign sat_sum     = {1'b0, r_hit_tot} + {2'b00, r_lqty};
    assign bid_pres    = XW'(r_r) < XW'(r_bid_cnt);
    assign ask_pres    = XW'(r_r) < XW'(r_ask_cnt);
    assign out_free    = !r_out_valid || !i_out_stall;
    assign tbl_full    = !r_found && !r_free_found;

    always_comb begin
        slot_we    = 1'b0;
        slot_waddr = r_fslot;
        slot_wdata = '0;
        slot_re    = 1'b0;
        lv_we      = 1'b0;
        lv_waddr   = r_hit_idx;
        lv_wdata   = lv_rd;
        lv_re      = 1'b0;
        lv_raddr   = LW'(r_li);
        case (i_cmd.op)
            OP_CLR: begin
                slot_we    = 1'b1;
                slot_waddr = r_ci;
            end
            OP_SCAN_RD: slot_re = 1'b1;
            OP_REM_SETUP: slot_we = 1'b1;
            OP_ADD_STORE: begin
                slot_we    = !tbl_full;
                slot_waddr = r_found ? r_fslot : r_free;
                slot_wdata = '{valid: 1'b1, side: r_in.side, qty: r_in.quantity,
                               price: r_in.price_ticks, key: r_in.order_key};
            end
            OP_LV_RD: lv_re = 1'b1;
            OP_LV_SATADD: begin
                lv_we    = 1'b1;
                lv_wdata = '{price: r_lprice,
                             total: sat_sum[32] ? '1 : sat_sum[31:0]};
            end
            OP_LV_SUB: begin
                lv_we    = 1'b1;
                lv_wdata = '{price: r_lprice, total: r_hit_tot - {1'b0, r_lqty}};
            end
            OP_REM_RD: begin
                lv_re    = 1'b1;
                lv_raddr = LW'(r_j + 1'b1);
            end
            OP_REM_WR, OP_INS_WR: begin
                lv_we    = 1'b1;
                lv_waddr = LW'(r_j);
            end
            OP_INS_RD: begin
                lv_re    = 1'b1;
                lv_raddr = LW'(r_j - 1'b1);
            end
            OP_INS_PUT: begin
                lv_we    = 1'b1;
                lv_waddr = LW'(r_pos);
                lv_wdata = '{price: r_lprice, total: {1'b0, r_lqty}};
            end
            OP_SNAP_RD: begin
                lv_re    = 1'b1;
                lv_raddr = LW'(r_r);
            end
            default: ;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (slot_we) r_slot_mem[slot_waddr] <= slot_wdata;
        if (slot_re) r_slot_rd <= r_slot_mem[r_si];
        if (lv_we && !r_lside) r_bid_mem[lv_waddr] <= lv_wdata;
        if (lv_we && r_lside)  r_ask_mem[lv_waddr] <= lv_wdata;
        if (lv_re) begin
            r_bid_rd <= r_bid_mem[lv_raddr];
            r_ask_rd <= r_ask_mem[lv_raddr];
        end
    end

    // Payload and working registers.
    always_ff @(posedge i_clk) begin
        case (i_cmd.op)
            OP_LATCH: begin
                r_in <= i_in_item;
                r_si <= '0;
            end
            OP_SCAN_INIT: r_si <= '0;
            OP_SCAN_CK: begin
                r_si <= r_si + 1'b1;
                if (hit_now) begin
                    r_fslot     <= r_si;
                    r_old_side  <= r_slot_rd.side;
                    r_old_price <= r_slot_rd.price;
                    r_old_qty   <= r_slot_rd.qty;
                end
                if (!r_slot_rd.valid && !r_free_found) r_free <= r_si;
            end
            OP_REM_SETUP: begin
                r_lside <= r_old_side[0];
                r_lprice <= r_old_price;
                r_lqty  <= r_old_qty;
                r_li    <= '0;
            end
            OP_ADD_STORE: begin
                r_lside  <= r_in.side[0];
                r_lprice <= r_in.price_ticks;
                r_lqty   <= r_in.quantity;
                r_li     <= '0;
                r_pos    <= in_side_cnt;
            end
            OP_LV_CK: begin
                r_li <= r_li + 1'b1;
                if (lv_hit_now) begin
                    r_hit_idx <= LW'(r_li);
                    r_hit_tot <= lv_rd.total;
                end
                if (!r_pos_found && ahead) r_pos <= r_li;
            end
            OP_REM_START: r_j <= CW'(r_hit_idx);
            OP_REM_WR:    r_j <= r_j + 1'b1;
            OP_INS_START: r_j <= lv_cnt;
            OP_INS_WR:    r_j <= r_j - 1'b1;
            OP_SNAP_INIT: r_r <= '0;
            OP_SNAP_LOAD: begin
                r_r   <= r_r + 1'b1;
                r_out <= '{level: 4'(r_r),
                           bid_price: bid_pres ? r_bid_rd.price : '0,
                           bid_total: bid_pres ? r_bid_rd.total : '0,
                           bid_present: bid_pres,
                           ask_price: ask_pres ? r_ask_rd.price : '0,
                           ask_total: ask_pres ? r_ask_rd.total : '0,
                           ask_present: ask_pres,
                           status: r_status,
                           last: r_r == RCW'(REPORT_DEPTH - 1)};
            end
            default: ;
        endcase
    end

    // Control registers.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ci         <= '0;
            r_found      <= 1'b0;
            r_free_found <= 1'b0;
            r_rem        <= 1'b0;
            r_pos_found  <= 1'b0;
            r_status     <= ST_OK;
            r_bid_cnt    <= '0;
            r_ask_cnt    <= '0;
            r_out_valid  <= 1'b0;
        end else begin
            if (i_cmd.op == OP_SNAP_LOAD) r_out_valid <= 1'b1;
            else if (!i_out_stall)        r_out_valid <= 1'b0;
            case (i_cmd.op)
                OP_CLR: r_ci <= r_ci + 1'b1;
                OP_LATCH: begin
                    r_found      <= 1'b0;
                    r_free_found <= 1'b0;
                    r_status     <= ST_OK;
                end
                OP_SCAN_INIT: begin
                    r_found      <= 1'b0;
                    r_free_found <= 1'b0;
                end
                OP_SCAN_CK: begin
                    if (hit_now) r_found <= 1'b1;
                    if (!r_slot_rd.valid) r_free_found <= 1'b1;
                end
                OP_REM_SETUP: begin
                    r_rem       <= 1'b1;
                    r_pos_found <= 1'b0;
                end
                OP_ADD_STORE: begin
                    r_rem       <= 1'b0;
                    r_pos_found <= 1'b0;
                    if (tbl_full) r_status <= ST_TABLE_FULL;
                end
                OP_LV_CK: if (ahead) r_pos_found <= 1'b1;
                OP_CNT_DEC: begin
                    if (r_lside) r_ask_cnt <= r_ask_cnt - 1'b1;
                    else         r_bid_cnt <= r_bid_cnt - 1'b1;
                end
                OP_INS_START: if (o_stat.lv_full) r_status <= ST_LEVELS_FULL;
                OP_INS_PUT: begin
                    if (r_lside) r_ask_cnt <= r_ask_cnt + 1'b1;
                    else         r_bid_cnt <= r_bid_cnt + 1'b1;
                end
                default: ;
            endcase
        end
    end

    always_comb begin
        o_stat.func        = r_in.func;
        o_stat.clr_last    = r_ci == SW'(ORDER_SLOTS - 1);
        o_stat.hit         = hit_now;
        o_stat.scan_last   = r_si == SW'(ORDER_SLOTS - 1);
        o_stat.tbl_full    = tbl_full;
        o_stat.old_side_ok = (r_old_side == SIDE_BID) || (r_old_side == SIDE_ASK);
        o_stat.in_side_ok  = (r_in.side == SIDE_BID) || (r_in.side == SIDE_ASK);
        o_stat.rem         = r_rem;
        o_stat.lv_done     = r_li >= lv_cnt;
        o_stat.lv_hit      = lv_hit_now;
        o_stat.rem_drop    = r_hit_tot <= {1'b0, r_lqty};
        o_stat.rem_more    = ({1'b0, r_j} + 1'b1) < {1'b0, lv_cnt};
        o_stat.lv_full     = lv_cnt >= CW'(BOOK_LEVELS);
        o_stat.ins_more    = r_j > r_pos;
        o_stat.out_free    = out_free;
        o_stat.snap_last   = r_r == RCW'(REPORT_DEPTH - 1);
    end

    assign o_out_valid = r_out_valid;
    assign o_out_item  = r_out;

    a_bid_cnt_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_bid_cnt <= CW'(BOOK_LEVELS))
        else $error("bid level count beyond store depth");
    a_ask_cnt_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_ask_cnt <= CW'(BOOK_LEVELS))
        else $error("ask level count beyond store depth");
    a_load_free: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_cmd.op == OP_SNAP_LOAD) |-> out_free)
        else $error("snapshot item overwrote an untaken item");
    a_last_rank: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_valid && r_out.last) |-> (r_out.level == 4'(REPORT_DEPTH - 1)))
        else $error("last flag on wrong rank");

endmodule

/* design/limit_order_book_top_levels.sv */
// Top level of the limit order book: order events in, top price levels of both sides out.
// After reset the order table is cleared one slot a cycle, all ORDER_SLOTS slots, during which
// no item is accepted. One event is worked at a time. The order table is a single-port memory
// searched linearly slot by slot, stopping at the matching key (an add of a new key scans all
// ORDER_SLOTS slots; a modify scans for the cancel and again for the add). A level update then
// scans the side's store level by level, and an insert or removal shifts the following levels
// one at a time. Finally REPORT_DEPTH result items are sent, each held back by any output stall,
// the last flagged with last.
module limit_order_book_top_levels #(
    parameter int ORDER_SLOTS  = lob_pkg::DEF_ORDER_SLOTS,
    parameter int BOOK_LEVELS  = lob_pkg::DEF_BOOK_LEVELS,
    parameter int REPORT_DEPTH = lob_pkg::DEF_REPORT_DEPTH
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_in_valid,
    output logic               o_in_stall,
    input  lob_pkg::t_in_item  i_in_item,
    output logic               o_out_valid,
    input  logic               i_out_stall,
    output lob_pkg::t_out_item o_out_item
);
    import lob_pkg::*;

    t_cmd     cmd;
    t_dp_stat stat;

    lob_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in_valid),
        .o_in_stall (o_in_stall),
        .i_stat     (stat),
        .o_cmd      (cmd)
    );

    lob_dpath #(
        .ORDER_SLOTS  (ORDER_SLOTS),
        .BOOK_LEVELS  (BOOK_LEVELS),
        .REPORT_DEPTH (REPORT_DEPTH)
    ) u_dpath (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_item   (i_in_item),
        .i_cmd       (cmd),
        .o_stat      (stat),
        .o_out_valid (o_out_valid),
        .i_out_stall (i_out_stall),
        .o_out_item  (o_out_item)
    );

endmodule

/* bench/tb_top.sv */
// Testbench for the limit order book top-levels block: directed and random order events.
`timescale 1ns / 100ps

module tb_top;
    import lob_pkg::*;

    localparam int SLOTS     = DEF_ORDER_SLOTS;
    localparam int LEVELS    = DEF_BOOK_LEVELS;
    localparam int DEPTH     = DEF_REPORT_DEPTH;
    localparam int MAX_CYCLES = 10_000_000;

    logic      i_clk = 1'b0;
    logic      i_rst_n = 1'b0;
    logic      i_in_valid = 1'b0;
    logic      o_in_stall;
    t_in_item  i_in_item = '0;
    logic      o_out_valid;
    logic      i_out_stall = 1'b0;
    t_out_item o_out_item;

    limit_order_book_top_levels DUT (
        .i_clk(i_clk), .i_rst_n(i_rst_n),
        .i_in_valid(i_in_valid), .o_in_stall(o_in_stall), .i_in_item(i_in_item),
        .o_out_valid(o_out_valid), .i_out_stall(i_out_stall), .o_out_item(o_out_item)
    );

    always #1 i_clk = ~i_clk;

    // Shadow book state.
    logic        sh_valid [SLOTS];
    logic [63:0] sh_key   [SLOTS];
    logic [31:0] sh_price [SLOTS];
    logic [30:0] sh_qty   [SLOTS];
    logic [1:0]  sh_side  [SLOTS];
    logic [31:0] bid_px [LEVELS];
    logic [31:0] bid_tot[LEVELS];
    int          bid_cnt;
    logic [31:0] ask_px [LEVELS];
    logic [31:0] ask_tot[LEVELS];
    int          ask_cnt;

    t_out_item snapshot_q[$];
    int        mismatches = 0;
    longint    cycles = 0;
    int        idle_mode = 1;
    int        out_wait = 0;
    logic [63:0] used_keys[$];

    function automatic int find_order(logic [63:0] key);
        for (int i = 0; i < SLOTS; i++)
            if (sh_valid[i] && sh_key[i] == key) return i;
        return -1;
    endfunction

    function automatic logic [1:0] level_insert(bit is_bid, logic [31:0] price,
                                                logic [30:0] qty);
        int n;
        int pos;
        logic [32:0] s;
        bit ahead;
        n = is_bid ? bid_cnt : ask_cnt;
        for (int i = 0; i < n; i++) begin
            if ((is_bid ? bid_px[i] : ask_px[i]) == price) begin
                s = (is_bid ? bid_tot[i] : ask_tot[i]) + qty;
                if (s[32]) s = 33'h0_FFFF_FFFF;
                if (is_bid) bid_tot[i] = s[31:0]; else ask_tot[i] = s[31:0];
                return ST_OK;
            end
        end
        if (n >= LEVELS) return ST_LEVELS_FULL;
        pos = n;
        for (int i = 0; i < n; i++) begin
            ahead = is_bid ? ($signed(price) > $signed(bid_px[i]))
                           : ($signed(price) < $signed(ask_px[i]));
            if (ahead) begin
                pos = i;
                break;
            end
        end
        for (int i = n; i > pos; i--) begin
            if (is_bid) begin
                bid_px[i] = bid_px[i-1]; bid_tot[i] = bid_tot[i-1];
            end else begin
                ask_px[i] = ask_px[i-1]; ask_tot[i] = ask_tot[i-1];
            end
        end
        if (is_bid) begin
            bid_px[pos] = price; bid_tot[pos] = qty; bid_cnt++;
        end else begin
            ask_px[pos] = price; ask_tot[pos] = qty; ask_cnt++;
        end
        return ST_OK;
    endfunction

    function automatic void level_take(bit is_bid, logic [31:0] price, logic [30:0] qty);
        int n;
        n = is_bid ? bid_cnt : ask_cnt;
        for (int i = 0; i < n; i++) begin
            if ((is_bid ? bid_px[i] : ask_px[i]) == price) begin
                if ((is_bid ? bid_tot[i] : ask_tot[i]) <= {1'b0, qty}) begin
                    for (int j = i; j < n - 1; j++) begin
                        if (is_bid) begin
                            bid_px[j] = bid_px[j+1]; bid_tot[j] = bid_tot[j+1];
                        end else begin
                            ask_px[j] = ask_px[j+1]; ask_tot[j] = ask_tot[j+1];
                        end
                    end
                    if (is_bid) bid_cnt--; else ask_cnt--;
                end else if (is_bid) begin
                    bid_tot[i] = bid_tot[i] - qty;
                end else begin
                    ask_tot[i] = ask_tot[i] - qty;
                end
                return;
            end
        end
    endfunction

    function automatic void cancel_order(logic [63:0] key);
        int s;
        s = find_order(key);
        if (s < 0) return;
        if (sh_side[s] == SIDE_BID) level_take(1, sh_price[s], sh_qty[s]);
        else if (sh_side[s] == SIDE_ASK) level_take(0, sh_price[s], sh_qty[s]);
        sh_valid[s] = 1'b0;
    endfunction

    function automatic logic [1:0] add_order(t_in_item it);
        int s;
        s = find_order(it.order_key);
        if (s < 0) begin
            for (int i = 0; i < SLOTS; i++)
                if (!sh_valid[i]) begin
                    s = i;
                    break;
                end
            if (s < 0) return ST_TABLE_FULL;
        end
        sh_valid[s] = 1'b1;
        sh_key[s] = it.order_key;
        sh_price[s] = it.price_ticks;
        sh_qty[s] = it.quantity;
        sh_side[s] = it.side;
        if (it.side == SIDE_BID) return level_insert(1, it.price_ticks, it.quantity);
        if (it.side == SIDE_ASK) return level_insert(0, it.price_ticks, it.quantity);
        return ST_OK;
    endfunction

    // Applies one event to the shadow book and queues the snapshot it yields.
    function automatic void apply_event(t_in_item it);
        logic [1:0] st;
        t_out_item o;
        st = ST_OK;
        case (it.func)
            FUNC_ADD:    st = add_order(it);
            FUNC_CANCEL: cancel_order(it.order_key);
            FUNC_MODIFY: begin
                cancel_order(it.order_key);
                st = add_order(it);
            end
            default: ;
        endcase
        for (int r = 0; r < DEPTH; r++) begin
            o = '0;
            o.level = r[3:0];
            if (r < bid_cnt) begin
                o.bid_price = bid_px[r]; o.bid_total = bid_tot[r]; o.bid_present = 1'b1;
            end
            if (r < ask_cnt) begin
                o.ask_price = ask_px[r]; o.ask_total = ask_tot[r]; o.ask_present = 1'b1;
            end
            o.status = st;
            o.last = (r == DEPTH - 1);
            snapshot_q.push_back(o);
        end
    endfunction

    function automatic int draw_gap();
        if (idle_mode == 0) return 0;
        return (idle_mode == 2) ? $urandom_range(0, 19) : (($urandom_range(0, 3) == 0) ?
               $urandom_range(0, 19) : 0);
    endfunction

    // Valid stays high after an item is taken until a gap or a drain lowers it; the block
    // raises its stall while it works each item, so the held item is never taken twice.
    task automatic send_event(t_in_item it);
        int gap;
        gap = draw_gap();
        if (gap > 0) begin
            i_in_valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        i_in_item <= it;
        i_in_valid <= 1'b1;
        // Stall follows the sequencer state only, so it is settled at the falling edge.
        @(negedge i_clk);
        while (o_in_stall) @(negedge i_clk);
        @(posedge i_clk);
        apply_event(it);
        used_keys.push_back(it.order_key);
    endtask

    function automatic t_in_item make_event(t_func f, logic [1:0] sd, logic [63:0] key,
                                            logic [31:0] px, logic [30:0] q);
        t_in_item it;
        it.func = f; it.side = sd; it.order_key = key; it.price_ticks = px; it.quantity = q;
        return it;
    endfunction

    task automatic wait_drained();
        i_in_valid <= 1'b0;
        while (snapshot_q.size() != 0) @(posedge i_clk);
        repeat (20) @(posedge i_clk);
    endtask

    // Output stall driver and result checker.
    always @(posedge i_clk) begin
        cycles <= cycles + 1;
        if (!i_rst_n) begin
            i_out_stall <= 1'b0;
            out_wait = 0;
        end else begin
            if (o_out_valid && !i_out_stall) begin
                if (snapshot_q.size() == 0) begin
                    mismatches++;
                    if (mismatches <= 10) $display("ERROR: unexpected result %p", o_out_item);
                end else begin
                    t_out_item e;
                    e = snapshot_q.pop_front();
                    if (e !== o_out_item) begin
                        mismatches++;
                        if (mismatches <= 10)
                            $display("ERROR: result mismatch\n  expected %p\n  actual   %p",
                                     e, o_out_item);
                    end
                end
                out_wait = $urandom_range(0, 19);
            end
            if (out_wait > 0) begin
                i_out_stall <= 1'b1;
                out_wait--;
            end else begin
                i_out_stall <= 1'b0;
            end
        end
        if (cycles > MAX_CYCLES) begin
            $display("Simulation FAILED");
            $finish;
        end
    end

    task automatic test_directed_extremes();
        send_event(make_event(FUNC_ADD, SIDE_BID, 64'd1, 32'sd100, 31'd5));
        send_event(make_event(FUNC_ADD, SIDE_BID, 64'd2, 32'h8000_0000, 31'h7FFF_FFFF));
        send_event(make_event(FUNC_ADD, SIDE_BID, 64'd3, 32'h7FFF_FFFF, 31'd0));
        send_event(make_event(FUNC_ADD, SIDE_ASK, 64'hFFFF_FFFF_FFFF_FFFF, 32'sd101,
                              31'h7FFF_FFFF));
        send_event(make_event(FUNC_ADD, SIDE_ASK, 64'd0, 32'sd101, 31'h7FFF_FFFF));
        // Saturates the ask level, then a cancel comes off the saturated total.
        send_event(make_event(FUNC_ADD, SIDE_ASK, 64'd5, 32'sd101, 31'd10));
        send_event(make_event(FUNC_CANCEL, SIDE_BID, 64'd5, 32'sd0, 31'd0));
        send_event(make_event(FUNC_ADD, SIDE_ASK, 64'd6, -32'sd50, 31'd1));
        send_event(make_event(FUNC_ADD, SIDE_BID, 64'd1, 32'sd100, 31'd7)); // overwrite
        send_event(make_event(FUNC_CANCEL, SIDE_ASK, 64'd1, 32'sd0, 31'd0));
        send_event(make_event(FUNC_CANCEL, SIDE_ASK, 64'd999, 32'sd0, 31'd0)); // unknown
        send_event(make_event(FUNC_MODIFY, SIDE_ASK, 64'd2, 32'sd102, 31'd3));
        send_event(make_event(FUNC_MODIFY, SIDE_BID, 64'd77, 32'sd90, 31'd4));
        send_event(make_event(FUNC_ADD, 2'd2, 64'd8, 32'sd55, 31'd9));
        send_event(make_event(FUNC_ADD, 2'd3, 64'd9, 32'sd55, 31'd9));
        send_event(make_event(FUNC_CANCEL, SIDE_BID, 64'd8, 32'sd0, 31'd0));
        send_event(make_event(FUNC_OTHER, SIDE_BID, 64'd6, 32'sd1, 31'd1));
        send_event(make_event(FUNC_CANCEL, SIDE_BID, 64'd3, 32'sd0, 31'd0));
    endtask

    task automatic test_level_store_full();
        // Fills the bid store past its depth; the extra levels report store full.
        for (int i = 0; i < LEVELS + 3; i++)
            send_event(make_event(FUNC_ADD, SIDE_BID, 64'h1000 + i, -32'sd1000 + i, 31'd2));
        wait_drained();
        for (int i = 0; i < LEVELS + 3; i++)
            send_event(make_event(FUNC_CANCEL, SIDE_BID, 64'h1000 + i, 32'sd0, 31'd0));
    endtask

    task automatic test_random_book();
        t_in_item it;
        for (int n = 0; n < 200; n++) begin
            idle_mode = (n < 40) ? 0 : ((n < 120) ? 1 : 2);
            it.func = t_func'($urandom_range(0, 9) < 5 ? FUNC_ADD :
                              $urandom_range(0, 9) < 6 ? FUNC_CANCEL :
                              $urandom_range(0, 9) < 8 ? FUNC_MODIFY : FUNC_OTHER);
            it.side = ($urandom_range(0, 19) == 0) ? 2'($urandom_range(2, 3))
                                                   : 2'($urandom_range(0, 1));
            if (it.func != FUNC_ADD && used_keys.size() != 0 && $urandom_range(0, 4) != 0)
                it.order_key = used_keys[$urandom_range(0, used_keys.size() - 1)];
            else if ($urandom_range(0, 9) == 0)
                it.order_key = {$urandom, $urandom};
            else
                it.order_key = 64'($urandom_range(0, 60));
            it.price_ticks = ($urandom_range(0, 9) == 0) ? 32'($urandom)
                             : 32'(10000 + $signed($urandom_range(0, 40)) - 20);
            it.quantity = ($urandom_range(0, 9) == 0) ? 31'($urandom)
                          : 31'($urandom_range(0, 500));
            send_event(it);
            if (n == 100) wait_drained();
        end
    endtask

    initial begin
        for (int i = 0; i < SLOTS; i++) sh_valid[i] = 1'b0;
        bid_cnt = 0;
        ask_cnt = 0;
        repeat (8) @(posedge i_clk);
        i_rst_n <= 1'b1;
        test_directed_extremes();
        test_level_store_full();
        test_random_book();
        wait_drained();
        if (mismatches == 0) $display("Simulation PASSED");
        else $display("Simulation FAILED");
        $finish;
    end

endmodule

/* sim.f */
design/lob_pkg.sv
design/lob_ctrl.sv
design/lob_dpath.sv
design/limit_order_book_top_levels.sv
bench/tb_top.sv
